FILE: rtl/ipfilt_pkg.sv
// types, constants and helpers shared by the prefix filter files
package ipfilt_pkg;

   // field widths fixed by the item format
   localparam int ADDR_W          = 32;
   localparam int PLEN_W          = 6;
   localparam int ACTION_W        = 2;
   localparam int STATUS_W        = 2;
   localparam int COUNT_W         = 5;
   localparam int MAX_ENTRIES_DEF = 16;
   localparam int PADDR_W         = 3;
   localparam int PDATA_W         = 32;

   localparam logic [PLEN_W-1:0] PREFIX_MAX = PLEN_W'(32);
   localparam logic [ADDR_W-1:0] FULL_MASK  = 32'hFFFF_FFFF;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_QUERY  = 2'd2
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_BADLEN = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_HOLD
   } state_type;

   // csr register indexes (paddr bit 2)
   typedef enum logic {
      REG_FILTER_ENABLED = 1'b0,
      REG_ALLOW_MODE     = 1'b1
   } reg_index_type;

   // token that walks the cell chain
   typedef struct packed {
      logic              valid;
      logic              query;
      logic              write;
      logic              match;
      logic [ADDR_W-1:0] address;
      logic [PLEN_W-1:0] plen;
   } token_type;

   // network mask for a prefix length of 0 to 32
   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
      prefix_mask = ~(FULL_MASK >> plen);
   endfunction

endpackage

FILE: rtl/ipfilt_if.sv
// request and response channel interfaces of the prefix filter

interface ipfilt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] address;
   logic [5:0]  prefix_len;

   modport source (output valid, output action, output address, output prefix_len,
                   input ready);
   modport sink   (input valid, input action, input address, input prefix_len,
                   output ready);
endinterface

interface ipfilt_rsp_if #(parameter int COUNT_W = ipfilt_pkg::COUNT_W);
   logic               valid;
   logic               ready;
   logic               allowed;
   logic               matched;
   logic [1:0]         status;
   logic [COUNT_W-1:0] entry_count;

   modport source (output valid, output allowed, output matched, output status,
                   output entry_count, input ready);
   modport sink   (input valid, input allowed, input matched, input status,
                   input entry_count, output ready);
endinterface

FILE: rtl/ipfilt_cell.sv
// one table entry of the prefix filter chain
module ipfilt_cell #(
   parameter int CNT_W = ipfilt_pkg::COUNT_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ipfilt_pkg::token_type tok_in,
   input  logic [CNT_W-1:0]      left_in,
   output ipfilt_pkg::token_type tok_out,
   output logic [CNT_W-1:0]      left_out
);
   import ipfilt_pkg::*;

   logic [ADDR_W-1:0] net_ff, net_in;
   logic [PLEN_W-1:0] plen_ff, plen_in;
   token_type         tok_ff, tok_in_nx;
   logic [CNT_W-1:0]  left_ff, left_in_nx;
   logic              occupied;
   logic              covers;

   // this entry holds data when entries remain ahead of the token
   assign occupied = (left_in != '0);
   assign covers   = ((tok_in.address ^ net_ff) & prefix_mask(plen_ff)) == '0;

   // compare on query, write the first free entry on append
   always_comb begin
      tok_in_nx  = tok_in;
      net_in     = net_ff;
      plen_in    = plen_ff;
      left_in_nx = occupied ? left_in - CNT_W'(1) : left_in;
      if (tok_in.valid && tok_in.query && occupied && covers) begin
         tok_in_nx.match = 1'b1;
      end
      if (tok_in.valid && tok_in.write && !occupied) begin
         net_in          = tok_in.address;
         plen_in         = tok_in.plen;
         tok_in_nx.write = 1'b0;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      net_ff  <= net_in;
      plen_ff <= plen_in;
   end

   // token stage toward the neighbor
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff  <= '0;
         left_ff <= '0;
      end else begin
         tok_ff  <= tok_in_nx;
         left_ff <= left_in_nx;
      end
   end

   assign tok_out  = tok_ff;
   assign left_out = left_ff;

endmodule

FILE: rtl/ipv4_prefix_allow_block_filter_unit.sv
// top level of the ipv4 prefix allow/block filter
// An IPv4 prefix access list of MAX_ENTRIES entries, one entry per cell in a
// chain. Each request word (clear, append or query) is taken when the block is
// idle and launched as a token through the chain: each cell compares the
// address against its own prefix or, for an append, stores the prefix in the
// first free cell. The block takes no new request until the token has been
// launched, has walked the chain, its result has been captured and the
// response loaded; the response word sits in an output register and a new
// request is accepted while it waits to be taken.
// The csr port holds filter_enabled at byte address 0 and allow_mode at 4.
module ipv4_prefix_allow_block_filter_unit #(
   parameter int MAX_ENTRIES = ipfilt_pkg::MAX_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   ipfilt_req_if.sink                        req_chan,
   ipfilt_rsp_if.source                      rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ipfilt_pkg::PADDR_W-1:0]    paddr,
   input  logic [ipfilt_pkg::PDATA_W-1:0]    pwdata,
   output logic [ipfilt_pkg::PDATA_W-1:0]    prdata,
   output logic                              pready
);
   import ipfilt_pkg::*;

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   state_type        state_ff, state_in;
   logic             enabled_ff, enabled_in;
   logic             allow_ff, allow_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       act_ff, act_in;
   status_type       status_ff, status_in;
   token_type        launch_ff, launch_in;
   logic [CNT_W-1:0] launch_left_ff, launch_left_in;
   logic             pend_allowed_ff, pend_allowed_in;
   logic             pend_matched_ff, pend_matched_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_allowed_ff, rsp_allowed_in;
   logic             rsp_matched_ff, rsp_matched_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;

   token_type        tok_chain  [0:MAX_ENTRIES];
   logic [CNT_W-1:0] left_chain [0:MAX_ENTRIES];

   logic             accept;
   logic             exit_hit;
   logic             load_rsp;
   logic             csr_write;
   logic             is_query;
   logic             append_ok;
   status_type       new_status;

   // cell chain
   assign tok_chain[0]  = launch_ff;
   assign left_chain[0] = launch_left_ff;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      ipfilt_cell #(.CNT_W(CNT_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .tok_in   (tok_chain[i]),
         .left_in  (left_chain[i]),
         .tok_out  (tok_chain[i+1]),
         .left_out (left_chain[i+1])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) state_in = S_RUN;
         end
         S_RUN: begin
            if (tok_chain[MAX_ENTRIES].valid) state_in = S_HOLD;
         end
         S_HOLD: begin
            if (!rsp_valid_ff || rsp_chan.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_chan.ready = 1'b0;
      exit_hit       = 1'b0;
      load_rsp       = 1'b0;
      unique case (state_ff)
         S_IDLE: req_chan.ready = 1'b1;
         S_RUN:  exit_hit = tok_chain[MAX_ENTRIES].valid;
         S_HOLD: load_rsp = !rsp_valid_ff || rsp_chan.ready;
         default: ;
      endcase
   end

   assign accept = req_chan.valid && req_chan.ready;

   // append checks: bad length before full table
   always_comb begin
      new_status = ST_OK;
      if (req_chan.action == ACT_APPEND) begin
         if (req_chan.prefix_len > PREFIX_MAX) begin
            new_status = ST_BADLEN;
         end else if (count_ff >= CNT_W'(MAX_ENTRIES)) begin
            new_status = ST_FULL;
         end
      end
   end

   assign is_query  = (req_chan.action == ACT_QUERY);
   assign append_ok = (req_chan.action == ACT_APPEND) && (new_status == ST_OK);

   // launch token and item bookkeeping
   always_comb begin
      launch_in       = launch_ff;
      launch_in.valid = 1'b0;
      launch_left_in  = launch_left_ff;
      act_in          = act_ff;
      status_in       = status_ff;
      if (accept) begin
         launch_in.valid   = 1'b1;
         launch_in.query   = is_query;
         launch_in.write   = append_ok;
         launch_in.match   = 1'b0;
         launch_in.address = req_chan.address;
         launch_in.plen    = req_chan.prefix_len;
         launch_left_in    = count_ff;
         act_in            = req_chan.action;
         status_in         = new_status;
      end
   end

   // verdict and entry count when the token leaves the chain
   always_comb begin
      pend_allowed_in = pend_allowed_ff;
      pend_matched_in = pend_matched_ff;
      count_in        = count_ff;
      if (exit_hit) begin
         pend_matched_in = 1'b0;
         pend_allowed_in = 1'b0;
         case (act_ff)
            ACT_CLEAR: count_in = '0;
            ACT_APPEND: begin
               if (status_ff == ST_OK) count_in = count_ff + CNT_W'(1);
            end
            ACT_QUERY: begin
               pend_matched_in = tok_chain[MAX_ENTRIES].match;
               if (!enabled_ff) begin
                  pend_allowed_in = 1'b1;
               end else if (allow_ff) begin
                  pend_allowed_in = tok_chain[MAX_ENTRIES].match;
               end else begin
                  pend_allowed_in = !tok_chain[MAX_ENTRIES].match;
               end
            end
            default: ;
         endcase
      end
   end

   // response register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_allowed_in = rsp_allowed_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      if (load_rsp) begin
         rsp_valid_in   = 1'b1;
         rsp_allowed_in = pend_allowed_ff;
         rsp_matched_in = pend_matched_ff;
         rsp_status_in  = status_ff;
         rsp_count_in   = count_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.allowed     = rsp_allowed_ff;
   assign rsp_chan.matched     = rsp_matched_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

   // csr writes
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      enabled_in = enabled_ff;
      allow_in   = allow_ff;
      if (csr_write) begin
         unique case (reg_index_type'(paddr[2]))
            REG_FILTER_ENABLED: enabled_in = pwdata[0];
            REG_ALLOW_MODE:     allow_in   = pwdata[0];
            default: ;
         endcase
      end
   end

   // csr reads
   always_comb begin
      prdata = '0;
      unique case (reg_index_type'(paddr[2]))
         REG_FILTER_ENABLED: prdata[0] = enabled_ff;
         REG_ALLOW_MODE:     prdata[0] = allow_ff;
         default: ;
      endcase
   end

   assign pready = 1'b1;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         enabled_ff   <= 1'b0;
         allow_ff     <= 1'b0;
         count_ff     <= '0;
         launch_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enabled_ff   <= enabled_in;
         allow_ff     <= allow_in;
         count_ff     <= count_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      launch_left_ff  <= launch_left_in;
      act_ff          <= act_in;
      status_ff       <= status_in;
      pend_allowed_ff <= pend_allowed_in;
      pend_matched_ff <= pend_matched_in;
      rsp_allowed_ff  <= rsp_allowed_in;
      rsp_matched_ff  <= rsp_matched_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_count_ff    <= rsp_count_in;
   end

endmodule

FILE: tb/sv/tb_ipv4_prefix_allow_block_filter_unit.sv
`timescale 1ns / 100ps
// self-checking testbench for the ipv4 prefix allow/block filter unit
module tb_ipv4_prefix_allow_block_filter_unit;
   import ipfilt_pkg::*;

   localparam int TABLE_DEPTH      = MAX_ENTRIES_DEF;
   localparam int RANDOM_PER_PHASE = 310;
   localparam int PHASE_COUNT      = 6;
   localparam int PRESSURE_PHASE   = 4;
   localparam int SETTLE_CYCLES    = TABLE_DEPTH + 8;
   localparam int HOLD_CYCLES      = 300;
   localparam int DRAIN_LIMIT      = 50000;
   localparam int MAX_PRINTED      = 60;
   localparam int SHADOW_DEPTH     = 32;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [ADDR_W-1:0]   address;
      logic [PLEN_W-1:0]   plen;
   } filter_req_type;

   typedef struct packed {
      logic               allowed;
      logic               matched;
      status_type         status;
      logic [COUNT_W-1:0] entry_count;
   } verdict_type;

   logic                 clock;
   logic                 reset;
   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [PADDR_W-1:0]   paddr;
   logic [PDATA_W-1:0]   pwdata;
   logic [PDATA_W-1:0]   prdata;
   logic                 pready;

   ipfilt_req_if req_bus ();
   ipfilt_rsp_if rsp_bus ();

   ipv4_prefix_allow_block_filter_unit #(
      .MAX_ENTRIES (TABLE_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // stimulus queue and expected verdicts
   filter_req_type pending_requests [$];
   verdict_type    expected_verdicts [$];
   filter_req_type drive_req;

   // shadow of the access list as the filter should hold it
   logic [ADDR_W-1:0] acl_network [TABLE_DEPTH];
   logic [PLEN_W-1:0] acl_plen [TABLE_DEPTH];
   int                acl_count = 0;
   logic              cfg_enabled = 1'b0;
   logic              cfg_allow = 1'b0;

   // prefixes handed out by the generator, used to aim queries
   logic [ADDR_W-1:0] aim_network [$];
   logic [PLEN_W-1:0] aim_plen [$];

   // idling knobs and receiver hold-off
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   int   hold_left = 0;
   logic hold_kick = 1'b0;

   // run statistics
   int error_count = 0;
   int n_query = 0;
   int n_hit = 0;
   int n_stored = 0;
   int n_full = 0;
   int n_badlen = 0;
   int n_clear = 0;
   int n_unused = 0;
   int n_csr = 0;
   int n_rsp = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_PRINTED) begin
         $display("mismatch at %0t: %s", $time, what);
      end
   endtask

   function automatic logic [ADDR_W-1:0] network_mask(input logic [PLEN_W-1:0] len);
      if (len == 0) begin
         return '0;
      end
      return FULL_MASK << (ADDR_W - len);
   endfunction

   // expected verdict of one accepted word, updating the shadow list
   task automatic apply_filter_request(input filter_req_type rq, output verdict_type v);
      logic hit;
      hit = 1'b0;
      v = '0;
      case (rq.action)
         ACT_CLEAR: begin
            acl_count = 0;
            n_clear++;
         end
         ACT_APPEND: begin
            if (rq.plen > PREFIX_MAX) begin
               v.status = ST_BADLEN;
               n_badlen++;
            end else if (acl_count >= TABLE_DEPTH) begin
               v.status = ST_FULL;
               n_full++;
            end else begin
               acl_network[acl_count] = rq.address;
               acl_plen[acl_count] = rq.plen;
               acl_count++;
               n_stored++;
            end
         end
         ACT_QUERY: begin
            for (int i = 0; i < acl_count; i++) begin
               if (((rq.address ^ acl_network[i]) & network_mask(acl_plen[i])) == '0) begin
                  hit = 1'b1;
               end
            end
            v.matched = hit;
            if (!cfg_enabled) begin
               v.allowed = 1'b1;
            end else if (cfg_allow) begin
               v.allowed = hit;
            end else begin
               v.allowed = ~hit;
            end
            n_query++;
            if (hit) begin
               n_hit++;
            end
         end
         default: begin
            n_unused++;
         end
      endcase
      v.entry_count = COUNT_W'(acl_count);
   endtask

   // request driver: holds each word until it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            drive_req = pending_requests.pop_front();
            req_bus.valid      <= 1'b1;
            req_bus.action     <= drive_req.action;
            req_bus.address    <= drive_req.address;
            req_bus.prefix_len <= drive_req.plen;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_kick) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // response ready with random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // check taken responses, then predict for taken requests
   always @(posedge clock) begin : verdict_monitor
      verdict_type exp_v;
      verdict_type next_v;
      filter_req_type taken;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch("response word with no request outstanding");
            end else begin
               exp_v = expected_verdicts.pop_front();
               if (rsp_bus.allowed !== exp_v.allowed || rsp_bus.matched !== exp_v.matched ||
                   rsp_bus.status !== exp_v.status ||
                   rsp_bus.entry_count !== exp_v.entry_count) begin
                  report_mismatch($sformatf(
                     "word %0d got allowed %b matched %b status %0d count %0d, want %b %b %0d %0d",
                     n_rsp, rsp_bus.allowed, rsp_bus.matched, rsp_bus.status,
                     rsp_bus.entry_count, exp_v.allowed, exp_v.matched, exp_v.status,
                     exp_v.entry_count));
               end
            end
            n_rsp++;
         end
         if (req_bus.valid && req_bus.ready) begin
            taken.action  = req_bus.action;
            taken.address = req_bus.address;
            taken.plen    = req_bus.prefix_len;
            apply_filter_request(taken, next_v);
            expected_verdicts.push_back(next_v);
         end
      end
   end

   task automatic queue_request(input logic [ACTION_W-1:0] action,
                                input logic [ADDR_W-1:0] address,
                                input logic [PLEN_W-1:0] plen);
      filter_req_type rq;
      rq.action  = action;
      rq.address = address;
      rq.plen    = plen;
      pending_requests.push_back(rq);
   endtask

   // mostly appends and aimed queries, with clears and noise mixed in
   task automatic queue_random_request();
      filter_req_type rq;
      int pick;
      int k;
      int bit_pos;
      logic [ADDR_W-1:0] m;
      pick = $urandom_range(99);
      rq.action  = ACT_QUERY;
      rq.address = $urandom;
      rq.plen    = PLEN_W'($urandom);
      if (pick < 2) begin
         rq.action = ACT_CLEAR;
      end else if (pick < 4) begin
         rq.action = ACT_UNUSED;
      end else if (pick < 40) begin
         rq.action = ACT_APPEND;
         k = $urandom_range(99);
         if (k < 8) begin
            rq.plen = PLEN_W'($urandom_range(63, 33));
         end else if (k < 10) begin
            rq.plen = '0;
         end else if (k < 16) begin
            rq.plen = PLEN_W'($urandom_range(7, 1));
         end else begin
            rq.plen = PLEN_W'($urandom_range(32, 8));
         end
         if (rq.plen <= PREFIX_MAX) begin
            aim_network.push_back(rq.address);
            aim_plen.push_back(rq.plen);
            if (aim_network.size() > SHADOW_DEPTH) begin
               void'(aim_network.pop_front());
               void'(aim_plen.pop_front());
            end
         end
      end else if (aim_network.size() != 0 && pick < 85) begin
         // inside a known prefix, or one bit off inside its network part
         k = $urandom_range(aim_network.size() - 1);
         m = network_mask(aim_plen[k]);
         rq.address = (aim_network[k] & m) | (rq.address & ~m);
         if (pick >= 70 && aim_plen[k] != 0) begin
            bit_pos = ADDR_W - $urandom_range(aim_plen[k], 1);
            rq.address[bit_pos] = ~rq.address[bit_pos];
         end
      end
      pending_requests.push_back(rq);
   endtask

   // apb write: setup cycle, then access cycle until pready
   task automatic write_csr(input reg_index_type idx, input logic value);
      logic [PDATA_W-1:0] word;
      word = $urandom;
      word[0] = value;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == REG_FILTER_ENABLED) begin
         cfg_enabled = value;
      end else begin
         cfg_allow = value;
      end
      n_csr++;
   endtask

   // wait until every queued word is taken and answered
   task automatic wait_idle();
      int cycles;
      cycles = 0;
      while ((pending_requests.size() != 0 || req_bus.valid || expected_verdicts.size() != 0)
             && cycles < DRAIN_LIMIT) begin
         @(negedge clock);
         cycles++;
      end
      if (expected_verdicts.size() != 0) begin
         report_mismatch($sformatf("%0d responses never arrived", expected_verdicts.size()));
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // run control
   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.action     = ACT_CLEAR;
      req_bus.address    = '0;
      req_bus.prefix_len = '0;
      rsp_bus.ready      = 1'b0;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: filter off, so every query is allowed
      queue_request(ACT_QUERY, 32'hC0A8_0001, 6'd0);
      queue_request(ACT_APPEND, 32'hC0A8_0000, 6'd24);
      queue_request(ACT_QUERY, 32'hC0A8_0001, 6'd0);
      queue_request(ACT_UNUSED, 32'hFFFF_FFFF, 6'd63);
      wait_idle();

      // directed: bad lengths, host and wide prefixes, full table, clear, /0
      write_csr(REG_FILTER_ENABLED, 1'b1);
      write_csr(REG_ALLOW_MODE, 1'b1);
      queue_request(ACT_APPEND, 32'h0000_0000, 6'd33);
      queue_request(ACT_APPEND, 32'hFFFF_FFFF, 6'd63);
      queue_request(ACT_APPEND, 32'hFFFF_FFFF, 6'd32);
      queue_request(ACT_APPEND, 32'h0A00_0000, 6'd8);
      queue_request(ACT_QUERY, 32'hFFFF_FFFF, 6'd0);
      queue_request(ACT_QUERY, 32'hFFFF_FFFE, 6'd0);
      queue_request(ACT_QUERY, 32'h0AFF_FFFF, 6'd0);
      queue_request(ACT_QUERY, 32'hC0A8_00FF, 6'd0);
      for (int i = 0; i < TABLE_DEPTH - 3; i++) begin
         queue_request(ACT_APPEND, $urandom, 6'($urandom_range(32, 16)));
      end
      queue_request(ACT_APPEND, 32'h0102_0304, 6'd16);
      queue_request(ACT_APPEND, 32'h0102_0304, 6'd40);
      queue_request(ACT_CLEAR, 32'h0000_0000, 6'd0);
      queue_request(ACT_QUERY, 32'hFFFF_FFFF, 6'd0);
      queue_request(ACT_APPEND, 32'h1234_5678, 6'd0);
      queue_request(ACT_QUERY, 32'h0000_0000, 6'd0);
      queue_request(ACT_QUERY, 32'hFFFF_FFFF, 6'd0);
      wait_idle();

      // random phases, each with its own settings and idling
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: begin
               write_csr(REG_FILTER_ENABLED, 1'b1);
               write_csr(REG_ALLOW_MODE, 1'b0);
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               write_csr(REG_ALLOW_MODE, 1'b1);
               send_idle_pct = 71;
               rsp_stall_pct = 0;
            end
            2: begin
               write_csr(REG_FILTER_ENABLED, 1'b0);
               send_idle_pct = 0;
               rsp_stall_pct = 71;
            end
            3: begin
               write_csr(REG_FILTER_ENABLED, 1'b1);
               write_csr(REG_ALLOW_MODE, 1'b0);
               send_idle_pct = 28;
               rsp_stall_pct = 28;
            end
            4: begin
               write_csr(REG_ALLOW_MODE, 1'b1);
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            default: begin
               write_csr(REG_FILTER_ENABLED, 1'b0);
               write_csr(REG_ALLOW_MODE, 1'b0);
               send_idle_pct = 71;
               rsp_stall_pct = 71;
            end
         endcase
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            queue_random_request();
         end
         if (p == PRESSURE_PHASE) begin
            // receiver stops while the sender keeps offering words
            @(posedge clock);
            hold_kick <= 1'b1;
            @(posedge clock);
            hold_kick <= 1'b0;
         end
         wait_idle();
      end

      $display("covered %0d words over %0d idling setups: %0d queries (%0d matched), %0d stored",
               n_rsp, PHASE_COUNT + 2, n_query, n_hit, n_stored);
      $display("dropped %0d on a full list and %0d on a bad length;", n_full, n_badlen);
      $display("%0d clears, %0d unused, %0d csr writes", n_clear, n_unused, n_csr);
      if (error_count == 0) begin
         $display("tb_ipv4_prefix_allow_block_filter_unit OK");
      end else begin
         $display("tb_ipv4_prefix_allow_block_filter_unit NOT OK");
      end
      $finish;
   end

   // overall watchdog
   initial begin
      #(5_000_000);
      $display("watchdog expired with %0d responses outstanding", expected_verdicts.size());
      $display("tb_ipv4_prefix_allow_block_filter_unit NOT OK");
      $finish;
   end

endmodule

FILE: ipv4_prefix_allow_block_filter_unit.f
rtl/ipfilt_pkg.sv
rtl/ipfilt_if.sv
rtl/ipfilt_cell.sv
rtl/ipv4_prefix_allow_block_filter_unit.sv
tb/sv/tb_ipv4_prefix_allow_block_filter_unit.sv
